// File: hdl/linear_array_queue_top_defines.svh
// assertion macros shared by the queue block
`ifndef LINEAR_ARRAY_QUEUE_TOP_DEFINES_SVH
`define LINEAR_ARRAY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LAQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/laq_pkg.sv
// types and constants of the linear array queue
`timescale 1ns / 1ps
package laq_pkg;

    localparam int DEPTH = 64;
    localparam int DATA_W = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0]
    {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_TRAV = 2'd2,
        OP_CAP  = 2'd3
    } op_t;

    typedef enum logic [1:0]
    {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_PART  = 2'd3
    } status_t;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_DEQ,
        BK_TRAV
    } back_state_t;

    typedef struct packed
    {
        op_t               op;
        logic [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed
    {
        status_t           status;
        logic [DATA_W-1:0] data;
        logic              last;
    } result_t;

endpackage

// File: hdl/laq_front.sv
// front end: takes input requests and decodes them into queue commands
`timescale 1ns / 1ps
module laq_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [laq_pkg::DATA_W-1:0]  s_tdata,   // value
    input  logic [1:0]                  s_tuser,   // func
    output logic                        cmd_valid,
    output laq_pkg::cmd_t               cmd,
    input  logic                        cmd_ready
);

    logic          hold_valid_reg;
    laq_pkg::cmd_t hold_reg;

    assign s_tready  = !hold_valid_reg || cmd_ready;
    assign cmd_valid = hold_valid_reg;
    assign cmd       = hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (cmd_ready)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            hold_reg.op    <= laq_pkg::op_t'(s_tuser);
            hold_reg.value <= s_tdata;
        end
    end

endmodule

// File: hdl/laq_cmd_fifo.sv
// short command queue between the front end and the execution back end
`timescale 1ns / 1ps
module laq_cmd_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  laq_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output laq_pkg::cmd_t pop_cmd
);

    laq_pkg::cmd_t                       slot_reg [laq_pkg::FIFO_DEPTH];
    logic [laq_pkg::FIFO_PTR_W-1:0]      wr_ptr_reg;
    logic [laq_pkg::FIFO_PTR_W-1:0]      rd_ptr_reg;
    logic [laq_pkg::FIFO_CNT_W-1:0]      count_reg;
    logic                                do_push;
    logic                                do_pop;

    assign push_ready = (count_reg != laq_pkg::FIFO_CNT_W'(laq_pkg::FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + laq_pkg::FIFO_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + laq_pkg::FIFO_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + laq_pkg::FIFO_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - laq_pkg::FIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hdl/laq_back.sv
// back end: queue storage, head and tail indices, sequencer and result register
`timescale 1ns / 1ps
module laq_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  laq_pkg::cmd_t               cmd,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [laq_pkg::DATA_W-1:0]  m_tdata,   // data
    output logic [1:0]                  m_tuser,   // status
    output logic                        m_tlast
);

    laq_pkg::back_state_t             state_reg;
    laq_pkg::back_state_t             state_next;
    logic [laq_pkg::CNT_W-1:0]        head_reg;
    logic [laq_pkg::CNT_W-1:0]        head_next;
    logic [laq_pkg::CNT_W-1:0]        tail_reg;
    logic [laq_pkg::CNT_W-1:0]        tail_next;
    logic [laq_pkg::CNT_W-1:0]        ptr_reg;
    logic [laq_pkg::CNT_W-1:0]        ptr_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    laq_pkg::result_t                 out_reg;
    laq_pkg::result_t                 out_next;

    logic [laq_pkg::DATA_W-1:0]       mem_reg [laq_pkg::DEPTH];
    logic [laq_pkg::DATA_W-1:0]       rd_data_reg;
    logic                             rd_en;
    logic [laq_pkg::IDX_W-1:0]        rd_addr;
    logic                             wr_en;

    logic                             out_free;
    logic [laq_pkg::CNT_W-1:0]        head_inc;
    logic [laq_pkg::CNT_W-1:0]        ptr_inc;
    logic                             is_full;
    logic                             is_empty;

    assign out_free = !out_valid_reg || m_tready;
    assign head_inc = head_reg + laq_pkg::CNT_W'(1);
    assign ptr_inc  = ptr_reg + laq_pkg::CNT_W'(1);
    assign is_full  = (tail_reg >= laq_pkg::CNT_W'(laq_pkg::DEPTH));
    assign is_empty = (head_reg == tail_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= laq_pkg::BK_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[tail_reg[laq_pkg::IDX_W-1:0]] <= cmd.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        cmd_ready      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = head_reg[laq_pkg::IDX_W-1:0];
        wr_en          = 1'b0;

        case (state_reg)
            laq_pkg::BK_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_ready     = 1'b1;
                    out_next.data = '0;
                    out_next.last = 1'b1;
                    case (cmd.op)
                        laq_pkg::OP_ENQ:
                        begin
                            out_valid_next = 1'b1;
                            if (is_full)
                            begin
                                out_next.status = laq_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                tail_next       = tail_reg + laq_pkg::CNT_W'(1);
                                out_next.status = laq_pkg::ST_DONE;
                            end
                        end
                        laq_pkg::OP_DEQ:
                        begin
                            if (is_empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_next.status = laq_pkg::ST_EMPTY;
                                head_next       = '0;
                                tail_next       = '0;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = laq_pkg::BK_DEQ;
                            end
                        end
                        laq_pkg::OP_TRAV:
                        begin
                            if (head_reg >= tail_reg)
                            begin
                                out_valid_next  = 1'b1;
                                out_next.status = laq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                ptr_next   = head_reg;
                                state_next = laq_pkg::BK_TRAV;
                            end
                        end
                        laq_pkg::OP_CAP:
                        begin
                            out_valid_next = 1'b1;
                            if (is_full)
                            begin
                                out_next.status = laq_pkg::ST_FULL;
                            end
                            else if (is_empty)
                            begin
                                out_next.status = laq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                out_next.status = laq_pkg::ST_PART;
                            end
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && !m_tready;
                        end
                    endcase
                end
            end
            laq_pkg::BK_DEQ:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next.status = laq_pkg::ST_DONE;
                    out_next.data   = rd_data_reg;
                    out_next.last   = 1'b1;
                    state_next      = laq_pkg::BK_IDLE;
                    if (head_inc == tail_reg)
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    else
                    begin
                        head_next = head_inc;
                    end
                end
            end
            laq_pkg::BK_TRAV:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next.status = laq_pkg::ST_DONE;
                    out_next.data   = rd_data_reg;
                    out_next.last   = (ptr_inc == tail_reg);
                    if (ptr_inc == tail_reg)
                    begin
                        state_next = laq_pkg::BK_IDLE;
                    end
                    else
                    begin
                        ptr_next = ptr_inc;
                        rd_en    = 1'b1;
                        rd_addr  = ptr_inc[laq_pkg::IDX_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = laq_pkg::BK_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/linear_array_queue_top.sv
// top level of the linear array queue
//
// input channel s_*: one request per item; s_tuser selects the operation
// (enqueue, dequeue, traverse, capacity check), s_tdata carries the word
// to append. output channel m_*: m_tuser is the status, m_tdata the word
// read, m_tlast marks the final result of a request.
// requests pass an input register and a two-entry command queue before
// the execution sequencer, so the source keeps going while results wait.
// enqueue and capacity check finish in the idle state; dequeue issues the
// registered storage read and answers from BK_DEQ; traverse answers from
// BK_TRAV one word per result, reading the next word as it goes.
// the queue is not circular: once the tail passes the last slot it
// reports full until a dequeue empties it and both indices return to zero.
// reset clears the indices, the command queue and the output valid flag;
// storage and result data keep their contents, no clearing pass is needed.
// a stalled receiver holds the result register; the sequencer waits, the
// command queue fills and then s_tready drops.
`timescale 1ns / 1ps
`include "linear_array_queue_top_defines.svh"
module linear_array_queue_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [laq_pkg::DATA_W-1:0]  s_tdata,   // value
    input  logic [1:0]                  s_tuser,   // func
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [laq_pkg::DATA_W-1:0]  m_tdata,   // data
    output logic [1:0]                  m_tuser,   // status
    output logic                        m_tlast
);

    logic          front_valid;
    logic          front_ready;
    laq_pkg::cmd_t front_cmd;
    logic          back_valid;
    logic          back_ready;
    laq_pkg::cmd_t back_cmd;

    laq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .cmd_ready (front_ready)
    );

    laq_cmd_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_cmd    (back_cmd)
    );

    laq_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    `LAQ_ASSERT_IMPL(a_status_zero_data, m_tvalid && (m_tuser != laq_pkg::ST_DONE), m_tdata == '0, "non-done result carries data")
    `LAQ_ASSERT_IMPL(a_status_last, m_tvalid && (m_tuser != laq_pkg::ST_DONE), m_tlast, "non-done result without last")
    `LAQ_ASSERT_IMPL(a_pop_needs_valid, back_ready, back_valid, "sequencer popped an empty command queue")
    `LAQ_ASSERT_NEXT(a_stall_backpressure, !s_tready, front_valid, "input stalled with empty holding register")

endmodule

// File: test/linear_array_queue_top_test.sv
// testbench for the linear array queue: random and directed requests checked against a predictor
`timescale 1ns / 1ps
module linear_array_queue_top_test;
    import laq_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int ITEM_COUNT   = 310;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD    = 300;

    typedef enum int
    {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    class queue_scoreboard;
        logic [DATA_W-1:0] slots [DEPTH];
        logic [6:0]        head_slot;
        logic [6:0]        tail_slot;
        result_t           expected_results [$];
        int                errors;
        int                results_seen;

        function new();
            head_slot    = '0;
            tail_slot    = '0;
            errors       = 0;
            results_seen = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void queue_result(status_t st, logic [DATA_W-1:0] word, logic fin);
            result_t r;
            r.status = st;
            r.data   = word;
            r.last   = fin;
            expected_results.push_back(r);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function bit is_full();
            return tail_slot >= DEPTH;
        endfunction

        // work out the results that one accepted request causes
        function void note_request(op_t op, logic [DATA_W-1:0] word);
            case (op)
                OP_ENQ:
                begin
                    if (tail_slot >= DEPTH)
                        queue_result(ST_FULL, '0, 1'b1);
                    else
                    begin
                        slots[tail_slot] = word;
                        tail_slot = tail_slot + 7'd1;
                        queue_result(ST_DONE, '0, 1'b1);
                    end
                end
                OP_DEQ:
                begin
                    if (head_slot == tail_slot)
                        queue_result(ST_EMPTY, '0, 1'b1);
                    else
                    begin
                        queue_result(ST_DONE, slots[head_slot], 1'b1);
                        head_slot = head_slot + 7'd1;
                    end
                    // indices fall back to zero once the queue drains
                    if (head_slot == tail_slot)
                    begin
                        head_slot = '0;
                        tail_slot = '0;
                    end
                end
                OP_TRAV:
                begin
                    if (head_slot >= tail_slot)
                        queue_result(ST_EMPTY, '0, 1'b1);
                    else
                        for (int i = head_slot; i < tail_slot; i++)
                            queue_result(ST_DONE, slots[i], (i + 1 == tail_slot));
                end
                default:
                begin
                    if (tail_slot >= DEPTH)
                        queue_result(ST_FULL, '0, 1'b1);
                    else if (head_slot == tail_slot)
                        queue_result(ST_EMPTY, '0, 1'b1);
                    else
                        queue_result(ST_PART, '0, 1'b1);
                end
            endcase
        endfunction

        task check_result(status_t st, logic [DATA_W-1:0] word, logic fin);
            result_t want;
            results_seen++;
            if (expected_results.size() == 0)
            begin
                report($sformatf("unexpected result status %0d data %h last %0b",
                                 st, word, fin));
                return;
            end
            want = expected_results.pop_front();
            if (st !== want.status)
                report($sformatf("status %0d, wanted %0d", st, want.status));
            if (word !== want.data)
                report($sformatf("data %h, wanted %h", word, want.data));
            if (fin !== want.last)
                report($sformatf("last %0b, wanted %0b", fin, want.last));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic [1:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;

    queue_scoreboard sb = new();
    int send_calm;
    int take_calm;
    int requests_sent;
    int cycle_count;
    bit long_hold_done;

    linear_array_queue_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // idle cycles per item, with runs of back-to-back items
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 5) == 0)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic op_t pick_op(mix_t mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                return (roll < 85) ? OP_ENQ : (roll < 90) ? OP_DEQ :
                       (roll < 95) ? OP_TRAV : OP_CAP;
            MIX_DRAIN:
                return (roll < 70) ? OP_DEQ : (roll < 80) ? OP_ENQ :
                       (roll < 90) ? OP_TRAV : OP_CAP;
            default:
                return op_t'(roll % 4);
        endcase
    endfunction

    task automatic send_request(input op_t op, input logic [DATA_W-1:0] word);
        int gap;
        gap = draw_wait(send_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(op, word);
        requests_sent++;
    endtask

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(status_t'(m_tuser), m_tdata, m_tlast);
    end

    // receiver side, with one long hold-off once results are flowing
    initial
    begin
        int hold;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            hold = draw_wait(take_calm);
            if (!long_hold_done && sb.results_seen >= 60)
            begin
                hold = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            @(negedge clk);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        mix_t mix;
        int   run_len;
        bit   first_run;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_ENQ;
        rst_n    = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // empty queue
        send_request(OP_CAP, rand_word());
        send_request(OP_DEQ, rand_word());
        send_request(OP_TRAV, rand_word());
        // extremes of the word
        send_request(OP_ENQ, 32'h8000_0000);
        send_request(OP_ENQ, 32'h7FFF_FFFF);
        send_request(OP_ENQ, 32'h0000_0000);
        send_request(OP_ENQ, 32'hFFFF_FFFF);
        send_request(OP_CAP, rand_word());
        send_request(OP_TRAV, rand_word());
        send_request(OP_DEQ, rand_word());
        send_request(OP_TRAV, rand_word());
        // drain to empty, indices back to zero
        send_request(OP_DEQ, rand_word());
        send_request(OP_DEQ, rand_word());
        send_request(OP_TRAV, rand_word());
        send_request(OP_DEQ, rand_word());
        send_request(OP_CAP, rand_word());
        send_request(OP_ENQ, 32'h5555_5555);
        send_request(OP_ENQ, 32'hAAAA_AAAA);
        send_request(OP_DEQ, rand_word());
        send_request(OP_DEQ, rand_word());
        send_request(OP_DEQ, rand_word());

        // random phases, the first one filling the queue past its last slot
        first_run = 1'b1;
        while (requests_sent < ITEM_COUNT)
        begin
            mix = first_run ? MIX_FILL : mix_t'($urandom_range(0, 2));
            run_len = first_run ? 90 : $urandom_range(8, 40);
            for (int k = 0; k < run_len && requests_sent < ITEM_COUNT; k++)
            begin
                if (first_run && sb.is_full())
                    send_request(op_t'($urandom_range(0, 3)), rand_word());
                else
                    send_request(pick_op(mix), rand_word());
            end
            first_run = 1'b0;
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
